[rtl/tccw_pkg.sv]
package tccw_pkg;

    localparam int COLUMNS = 80;
    localparam int ROWS    = 25;
    localparam int CELLS   = COLUMNS * ROWS;
    localparam int CELL_W  = $clog2(CELLS + 1);
    localparam int ADDR_W  = $clog2(CELLS);
    localparam int COL_W   = $clog2(COLUMNS);
    localparam int OUT_W   = 2 * CELL_W + 19;
    localparam int TDATA_W = ((OUT_W + 7) / 8) * 8;

    localparam logic [7:0] CODE_NUL = 8'h00;
    localparam logic [7:0] CODE_BS  = 8'h08;
    localparam logic [7:0] CODE_NL  = 8'h0a;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_WALK
    } seq_state_t;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        data;
    } store_wr_t;

    typedef struct packed {
        logic              overflow;
        logic [7:0]        cell_attr;
        logic [7:0]        cell_char;
        logic [CELL_W-1:0] cell_index;
        logic              attr_written;
        logic              char_written;
        logic [CELL_W-1:0] cursor_cell;
    } result_t;

endpackage

[rtl/tccw_store.sv]
module tccw_store (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  tccw_pkg::store_wr_t       wr,
    input  logic [tccw_pkg::ADDR_W-1:0] rd_addr,
    output logic [7:0]                rd_data,
    output logic                      clear_done
);
    import tccw_pkg::*;

    logic [7:0]        mem [CELLS];
    logic [7:0]        rd_data_reg;
    logic [ADDR_W-1:0] clr_cnt_reg, clr_cnt_next;
    logic              clr_busy_reg, clr_busy_next;
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [7:0]        wdata;

    // sweep zeros through every cell after reset
    always_comb begin
        clr_cnt_next  = clr_cnt_reg;
        clr_busy_next = clr_busy_reg;
        if (clr_busy_reg) begin
            clr_cnt_next = clr_cnt_reg + 1'b1;
            if (clr_cnt_reg == ADDR_W'(CELLS - 1)) begin
                clr_busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_cnt_reg  <= '0;
            clr_busy_reg <= 1'b1;
        end else begin
            clr_cnt_reg  <= clr_cnt_next;
            clr_busy_reg <= clr_busy_next;
        end
    end

    assign we    = clr_busy_reg || wr.we;
    assign waddr = clr_busy_reg ? clr_cnt_reg : wr.addr;
    assign wdata = clr_busy_reg ? 8'h00 : wr.data;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data    = rd_data_reg;
    assign clear_done = !clr_busy_reg;

endmodule

[rtl/tccw_seq.sv]
module tccw_seq (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        clear_done,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [7:0]                  char_code,
    input  logic [7:0]                  text_attr,
    input  logic                        res_ready,
    output logic                        res_valid,
    output tccw_pkg::result_t           result,
    output tccw_pkg::store_wr_t         wr,
    output logic [tccw_pkg::ADDR_W-1:0] rd_addr,
    input  logic [7:0]                  rd_data
);
    import tccw_pkg::*;

    seq_state_t        state_reg, state_next;
    logic [7:0]        code_reg, code_next;
    logic [CELL_W-1:0] cursor_reg, cursor_next;
    logic [COL_W-1:0]  col_reg, col_next;
    logic [CELL_W-1:0] pos_reg, pos_next;
    logic [COL_W-1:0]  pcol_reg, pcol_next;

    logic              is_nul, is_nl, is_bs, at_end;
    logic [CELL_W:0]   add_base, add_op, add_sum;
    logic [CELL_W-1:0] step_pos, nl_target;
    logic [COL_W-1:0]  col_base, col_dn, col_up;
    logic              walk_more;
    logic              go_walk, finish;
    logic [CELL_W-1:0] cursor_after;
    logic [COL_W-1:0]  col_after;

    assign is_nul = code_reg == CODE_NUL;
    assign is_nl  = code_reg == CODE_NL;
    assign is_bs  = code_reg == CODE_BS;
    assign at_end = cursor_reg >= CELL_W'(CELLS);

    // shared cursor adder: +1, +to next row, or -1
    always_comb begin
        add_base = (state_reg == ST_WALK) ? {1'b0, pos_reg} : {1'b0, cursor_reg};
        if (is_bs || state_reg == ST_WALK) begin
            add_op = '1;
        end else if (is_nl) begin
            add_op = (CELL_W+1)'(COLUMNS) - (CELL_W+1)'(col_reg);
        end else begin
            add_op = (CELL_W+1)'(1);
        end
        add_sum   = add_base + add_op;
        step_pos  = add_sum[CELL_W-1:0];
        nl_target = (add_sum > (CELL_W+1)'(CELLS)) ? CELL_W'(CELLS) : add_sum[CELL_W-1:0];
    end

    always_comb begin
        col_base = (state_reg == ST_WALK) ? pcol_reg : col_reg;
        col_dn   = (col_base == '0) ? COL_W'(COLUMNS - 1) : col_base - 1'b1;
        col_up   = (col_reg == COL_W'(COLUMNS - 1)) ? '0 : col_reg + 1'b1;
    end

    assign walk_more = (pos_reg != '0) && (rd_data == 8'h00);

    // outputs: handshakes, store port, result
    always_comb begin
        in_ready     = (state_reg == ST_IDLE) && clear_done;
        res_valid    = 1'b0;
        result       = '0;
        wr           = '0;
        rd_addr      = pos_reg[ADDR_W-1:0];
        go_walk      = 1'b0;
        finish       = 1'b0;
        cursor_after = cursor_reg;
        col_after    = col_reg;
        unique case (state_reg)
            ST_IDLE: begin
            end
            ST_EXEC: begin
                if (is_bs && cursor_reg != '0) begin
                    go_walk = 1'b1;
                    rd_addr = step_pos[ADDR_W-1:0];
                end else begin
                    res_valid = 1'b1;
                    if (is_nul || is_bs) begin
                        // nothing to write
                    end else if (at_end) begin
                        result.overflow = 1'b1;
                    end else if (is_nl) begin
                        wr.we               = res_ready;
                        result.char_written = 1'b1;
                        result.cell_char    = CODE_NL;
                        result.cell_index   = cursor_reg;
                        cursor_after        = nl_target;
                        col_after           = '0;
                    end else begin
                        wr.we               = res_ready;
                        result.char_written = 1'b1;
                        result.attr_written = 1'b1;
                        result.cell_char    = code_reg;
                        result.cell_attr    = text_attr;
                        result.cell_index   = cursor_reg;
                        cursor_after        = step_pos;
                        col_after           = col_up;
                    end
                    wr.addr   = cursor_reg[ADDR_W-1:0];
                    wr.data   = code_reg;
                    finish    = res_ready;
                end
            end
            ST_WALK: begin
                if (walk_more) begin
                    rd_addr = step_pos[ADDR_W-1:0];
                end else begin
                    res_valid           = 1'b1;
                    wr.we               = res_ready;
                    wr.addr             = pos_reg[ADDR_W-1:0];
                    wr.data             = 8'h00;
                    result.char_written = 1'b1;
                    result.attr_written = 1'b1;
                    result.cell_index   = pos_reg;
                    cursor_after        = pos_reg;
                    col_after           = pcol_reg;
                    finish              = res_ready;
                end
            end
            default: begin
            end
        endcase
        result.cursor_cell = cursor_after;
    end

    // next state
    always_comb begin
        state_next  = state_reg;
        code_next   = code_reg;
        cursor_next = cursor_reg;
        col_next    = col_reg;
        pos_next    = pos_reg;
        pcol_next   = pcol_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_valid && in_ready) begin
                    code_next  = char_code;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (go_walk) begin
                    pos_next   = step_pos;
                    pcol_next  = col_dn;
                    state_next = ST_WALK;
                end else if (finish) begin
                    cursor_next = cursor_after;
                    col_next    = col_after;
                    state_next  = ST_IDLE;
                end
            end
            ST_WALK: begin
                if (walk_more) begin
                    pos_next  = step_pos;
                    pcol_next = col_dn;
                end else if (finish) begin
                    cursor_next = cursor_after;
                    col_next    = col_after;
                    state_next  = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            cursor_reg <= '0;
            col_reg    <= '0;
        end else begin
            state_reg  <= state_next;
            cursor_reg <= cursor_next;
            col_reg    <= col_next;
        end
    end

    always_ff @(posedge aclk) begin
        code_reg <= code_next;
        pos_reg  <= pos_next;
        pcol_reg <= pcol_next;
    end

endmodule

[rtl/text_console_char_writer_unit.sv]
// Flow: NUL, newline and printable codes are registered into state EXEC, which passes the
// result to the output register. Backspace away from cell 0 walks back in state WALK over
// empty cells; the walk reads one cell of the character store per cycle.
// One item in flight at a time: s_tready is high only in state IDLE.
// Reset: synchronous, active low; afterwards a pass writes zero to every cell of the store,
// with s_tready low until it ends. Attribute register and cursor reset to 0.
module text_console_char_writer_unit (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [7:0]                   s_tdata,   // char_code
    output logic                         m_tvalid,
    input  logic                         m_tready,
    // cursor_cell, char_written, attr_written, cell_index, cell_char, cell_attr,
    // overflow, zero fill
    output logic [tccw_pkg::TDATA_W-1:0] m_tdata,
    input  logic                         cfg_wr_en,
    input  logic [7:0]                   cfg_wr_data // text_attribute
);
    import tccw_pkg::*;

    logic [7:0]         text_attr_reg;
    logic               m_tvalid_reg, m_tvalid_next;
    logic [TDATA_W-1:0] m_tdata_reg;
    logic               res_valid, res_ready;
    result_t            result;
    store_wr_t          wr;
    logic [ADDR_W-1:0]  rd_addr;
    logic [7:0]         rd_data;
    logic               clear_done;

    tccw_store u_store (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .wr         (wr),
        .rd_addr    (rd_addr),
        .rd_data    (rd_data),
        .clear_done (clear_done)
    );

    tccw_seq u_seq (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .clear_done (clear_done),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .char_code  (s_tdata),
        .text_attr  (text_attr_reg),
        .res_ready  (res_ready),
        .res_valid  (res_valid),
        .result     (result),
        .wr         (wr),
        .rd_addr    (rd_addr),
        .rd_data    (rd_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            text_attr_reg <= '0;
        end else if (cfg_wr_en) begin
            text_attr_reg <= cfg_wr_data;
        end
    end

    // output register: hold a beat until taken
    assign res_ready = !m_tvalid_reg || m_tready;

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (res_valid && res_ready) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid && res_ready) begin
            m_tdata_reg <= TDATA_W'(result);
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    result_t out_view;
    assign out_view = result_t'(m_tdata_reg[OUT_W-1:0]);

    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while an item is in flight");

    a_attr_needs_char: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && out_view.attr_written |-> out_view.char_written)
        else $error("attribute write without character write");

    a_overflow_no_write: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && out_view.overflow |-> !out_view.char_written)
        else $error("write reported together with overflow");

    a_cursor_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> out_view.cursor_cell <= CELL_W'(CELLS))
        else $error("cursor past the end of the screen");

endmodule

[dv/tb_top.sv]
module tb_top;
    import tccw_pkg::*;

    logic                 aclk        = 1'b0;
    logic                 aresetn     = 1'b0;
    logic                 s_tvalid    = 1'b0;
    logic                 s_tready;
    logic [7:0]           s_tdata     = 8'h00;   // char_code
    logic                 m_tvalid;
    logic                 m_tready    = 1'b0;
    // cursor_cell, char_written, attr_written, cell_index, cell_char, cell_attr,
    // overflow, zero fill
    logic [TDATA_W-1:0]   m_tdata;
    logic                 cfg_wr_en   = 1'b0;
    logic [7:0]           cfg_wr_data = 8'h00;   // text_attribute

    always #2 aclk = ~aclk;

    text_console_char_writer_unit DUT (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    // Console mirror: cursor, character bytes and attribute register
    int         cursor;
    logic [7:0] screen_chars [CELLS];
    logic [7:0] attr_reg;
    result_t    console_q [$];
    int         mismatches;
    int         ready_hold;
    bit         calm;

    function automatic int draw_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [7:0] draw_printable();
        logic [7:0] c;
        do c = 8'($urandom_range(1, 255)); while (c == CODE_BS || c == CODE_NL);
        return c;
    endfunction

    function automatic result_t console_putc(input logic [7:0] code);
        result_t r;
        r = '0;
        if (code == CODE_NL) begin
            if (cursor < CELLS) begin
                screen_chars[cursor] = CODE_NL;
                r.char_written = 1'b1;
                r.cell_index   = CELL_W'(cursor);
                r.cell_char    = CODE_NL;
                cursor = cursor + COLUMNS - (cursor % COLUMNS);
                if (cursor > CELLS) cursor = CELLS;
            end else begin
                r.overflow = 1'b1;
            end
        end else if (code == CODE_BS) begin
            if (cursor > 0) begin
                // walk back over empty cells, stop at cell 0
                cursor--;
                while (cursor > 0 && screen_chars[cursor] == 8'h00) cursor--;
                screen_chars[cursor] = 8'h00;
                r.char_written = 1'b1;
                r.attr_written = 1'b1;
                r.cell_index   = CELL_W'(cursor);
            end
        end else if (code != CODE_NUL) begin
            if (cursor < CELLS) begin
                screen_chars[cursor] = code;
                r.char_written = 1'b1;
                r.attr_written = 1'b1;
                r.cell_index   = CELL_W'(cursor);
                r.cell_char    = code;
                r.cell_attr    = attr_reg;
                cursor++;
            end else begin
                r.overflow = 1'b1;
            end
        end
        r.cursor_cell = CELL_W'(cursor);
        return r;
    endfunction

    task automatic send_char(input logic [7:0] code);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= code;
        do @(posedge aclk); while (!s_tready);
        console_q.push_back(console_putc(code));
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (console_q.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic set_attribute(input logic [7:0] a);
        wait_drained();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= a;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        attr_reg = a;
    endtask

    task automatic check_beat(input result_t got);
        result_t want;
        if (console_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected beat: %h", got);
            return;
        end
        want = console_q.pop_front();
        if (got.cursor_cell !== want.cursor_cell || got.char_written !== want.char_written ||
            got.attr_written !== want.attr_written || got.cell_index !== want.cell_index ||
            got.cell_char !== want.cell_char || got.cell_attr !== want.cell_attr ||
            got.overflow !== want.overflow) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("mismatch exp: cur=%0d cw=%0d aw=%0d idx=%0d ch=%h at=%h ovf=%0d",
                         want.cursor_cell, want.char_written, want.attr_written,
                         want.cell_index, want.cell_char, want.cell_attr, want.overflow);
                $display("         got: cur=%0d cw=%0d aw=%0d idx=%0d ch=%h at=%h ovf=%0d",
                         got.cursor_cell, got.char_written, got.attr_written,
                         got.cell_index, got.cell_char, got.cell_attr, got.overflow);
            end
        end
    endtask

    // Result side: check each beat, stall tready at random
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            check_beat(result_t'(m_tdata[OUT_W-1:0]));
        if (ready_hold > 0) begin
            ready_hold--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
            ready_hold = draw_gap();
        end
    end

    task automatic test_directed_codes();
        logic [7:0] codes [$];
        set_attribute(8'hFF);
        // backspace at cell 0, NUL, extremes, then walks back over newline gaps
        codes = {CODE_BS, CODE_NUL, 8'hFF, 8'h01, 8'h80, CODE_BS, CODE_NL, CODE_BS,
                 8'h7F, CODE_NL, CODE_NL, CODE_BS, CODE_BS};
        foreach (codes[i]) send_char(codes[i]);
        set_attribute(8'h00);
        // other control codes print; then walk all the way down to cell 0
        codes = {8'h09, 8'h0D, 8'h1B, CODE_BS, CODE_BS, CODE_BS, CODE_BS, CODE_BS, CODE_BS};
        foreach (codes[i]) send_char(codes[i]);
    endtask

    task automatic test_screen_edge();
        set_attribute(8'hA5);
        while (cursor < CELLS) send_char(CODE_NL);
        // cursor past screen: printable and newline overflow, NUL is silent
        send_char(draw_printable());
        send_char(CODE_NL);
        send_char(CODE_NUL);
        send_char(CODE_BS);
        while (cursor < CELLS) send_char(draw_printable());
        send_char(8'hFF);
        send_char(CODE_BS);
        send_char(CODE_NL);   // newline on the last row lands past screen
        send_char(CODE_NL);
        repeat (5) send_char(CODE_BS);
    endtask

    task automatic test_random_text();
        logic [7:0] attrs [5];
        int         n;
        int         len;
        int         r;
        attrs = '{8'h00, 8'hFF, 8'($urandom), 8'($urandom), 8'($urandom)};
        foreach (attrs[p]) begin
            set_attribute(attrs[p]);
            n = 0;
            while (n < 100) begin
                if ($urandom_range(0, 39) == 0) calm = !calm;
                r = $urandom_range(0, 99);
                if (r < 6) begin
                    len = $urandom_range(3, 20);
                    repeat (len) send_char(CODE_BS);
                end else if (r < 9) begin
                    len = $urandom_range(2, 8);
                    repeat (len) send_char(CODE_NL);
                end else begin
                    len = 1;
                    r = $urandom_range(0, 99);
                    if (r < 70)      send_char(draw_printable());
                    else if (r < 80) send_char(CODE_NL);
                    else if (r < 90) send_char(CODE_BS);
                    else if (r < 94) send_char(CODE_NUL);
                    else             send_char(8'($urandom_range(0, 255)));
                end
                n += len;
            end
        end
        calm = 1'b0;
    endtask

    initial begin
        cursor   = 0;
        attr_reg = 8'h00;
        foreach (screen_chars[i]) screen_chars[i] = 8'h00;
        mismatches = 0;
        ready_hold = 0;
        calm       = 1'b0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        test_directed_codes();
        test_screen_edge();
        test_random_text();

        wait_drained();
        repeat (50) @(posedge aclk);
        if (mismatches == 0 && console_q.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        #30_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
